// File: hdl/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  // Field widths of the stream words and the configuration port
  localparam int unsigned OP_W        = 1;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned FRAME_W     = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned WIU_W       = 7;
  localparam int unsigned FW_W        = 6;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WORD   = 1'b1;

  localparam logic [WIU_W-1:0] WORDS_IN_USE_RST = 7'd64;
  localparam logic [FW_W-1:0]  FIRST_WORD_RST   = 6'd0;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_NOROOM = 2'd1,
    ST_BADREQ = 2'd2
  } bfa_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_FINISH
  } bfa_state_e;

  typedef struct packed {
    logic        load_in;
    logic        clr_step;
    logic        alloc_start;
    logic        scan_next;
    logic        scan_hit;
    logic        free_init;
    logic        free_rd;
    logic        free_wr;
    logic        set_status;
    bfa_status_e status_val;
    logic        load_out;
  } bfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_count;
    logic op_free;
    logic no_search;
    logic scan_hit;
    logic scan_end;
    logic free_past_end;
    logic free_last;
    logic out_busy;
  } bfa_stat_t;

endpackage

// File: hdl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
`timescale 1ns / 1ps

module bfa_ctrl import bfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bfa_stat_t stat_i,
  output bfa_cmd_t  cmd_o
);

  bfa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.bad_count) begin
          state_d = S_FINISH;
        end else if (stat_i.op_free) begin
          state_d = S_FREE_RD;
        end else if (stat_i.no_search) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_hit || stat_i.scan_end) state_d = S_FINISH;
      end
      S_FREE_RD: begin
        state_d = stat_i.free_past_end ? S_FINISH : S_FREE_WR;
      end
      S_FREE_WR: begin
        state_d = stat_i.free_last ? S_FINISH : S_FREE_RD;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.status_val = ST_DONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DECIDE: begin
        cmd_o.set_status = 1'b1;
        if (stat_i.bad_count) begin
          cmd_o.status_val = ST_BADREQ;
        end else if (stat_i.op_free) begin
          cmd_o.status_val = ST_DONE;
          cmd_o.free_init  = 1'b1;
        end else if (stat_i.no_search) begin
          cmd_o.status_val = ST_NOROOM;
        end else begin
          cmd_o.set_status  = 1'b0;
          cmd_o.alloc_start = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.scan_hit   = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_DONE;
        end else if (stat_i.scan_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = ST_NOROOM;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_FREE_RD: begin
        cmd_o.free_rd = !stat_i.free_past_end;
      end
      S_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
      end
      S_FINISH: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: hdl/bfa_dp.sv
// Datapath: bitmap RAM, word scan, fit search, free run walk and result register.
`timescale 1ns / 1ps

module bfa_dp import bfa_pkg::*; #(
  parameter int unsigned BITMAP_WORDS = 64,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfa_cmd_t              cmd_i,
  output bfa_stat_t             stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       in_op_i,
  input  logic [COUNT_W-1:0]    in_count_i,
  input  logic [FRAME_W-1:0]    in_frame_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [FRAME_W-1:0]    out_frame_o
);

  localparam int unsigned AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int unsigned WW  = $clog2(BITMAP_WORDS + 1);
  localparam int unsigned CW  = (WW > 12) ? WW : 12;
  localparam int unsigned BIW = $clog2(WORD_BITS);
  localparam int unsigned PW  = CW + 8;
  localparam logic [CW-1:0] WORDS_C = CW'(BITMAP_WORDS);
  localparam logic [7:0]    WB8     = 8'(WORD_BITS);

  // Mask of the lowest k bits of a word
  function automatic logic [WORD_BITS-1:0] run_mask(input logic [7:0] k);
    logic [WORD_BITS-1:0] m;
    if (k >= WB8) begin
      m = '1;
    end else begin
      m = ~({WORD_BITS{1'b1}} << k);
    end
    return m;
  endfunction

  // Configuration
  logic [WIU_W-1:0] words_in_use_q;
  logic [FW_W-1:0]  first_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_in_use_q <= WORDS_IN_USE_RST;
      first_word_q   <= FIRST_WORD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WORDS_IN_USE: words_in_use_q <= cfg_data_i;
        CFG_FIRST_WORD:   first_word_q   <= cfg_data_i[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // Work registers
  logic [CW-1:0]        word_q, word_d;
  logic                 out_valid_q, out_valid_d;
  logic [BIW-1:0]       bit_q, bit_d;
  logic [OP_W-1:0]      op_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  bfa_status_e          rstat_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [FRAME_W-1:0]   out_frame_q;

  // RAM port signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Search limit and word stepping
  logic [CW-1:0] limit;
  logic [CW-1:0] word_inc;
  logic [CW-1:0] first_word_ext;

  assign limit = (CW'(words_in_use_q) > WORDS_C) ? WORDS_C : CW'(words_in_use_q);
  assign word_inc = word_q + CW'(1);
  assign first_word_ext = CW'(first_word_q);

  // First-fit search inside the word just read
  logic [WORD_BITS-1:0] alloc_run;
  logic [WORD_BITS-1:0] fit;
  logic [BIW-1:0]       hit_pos;

  assign alloc_run = run_mask(8'(count_q));

  always_comb begin
    fit = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      fit[p] = ((8'(p) + 8'(count_q)) <= WB8) && ((ram_rdata & (alloc_run << p)) == '0);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (fit[p]) hit_pos = BIW'(p);
    end
  end

  // Free: bits of the current word that fall inside the run
  logic [7:0]           room;
  logic [7:0]           take;
  logic [WORD_BITS-1:0] free_mask;

  assign room      = WB8 - 8'(bit_q);
  assign take      = (8'(count_q) < room) ? 8'(count_q) : room;
  assign free_mask = run_mask(take) << bit_q;

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q[AW-1:0];
    ram_wdata = '0;
    ram_raddr = word_q[AW-1:0];
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.scan_hit) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata | (alloc_run << hit_pos);
    end else if (cmd_i.free_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata & ~free_mask;
    end
    if (cmd_i.alloc_start) begin
      ram_raddr = first_word_ext[AW-1:0];
    end else if (cmd_i.scan_next) begin
      ram_raddr = word_inc[AW-1:0];
    end
  end

  always_comb begin
    word_d  = word_q;
    bit_d   = bit_q;
    count_d = count_q;
    frame_d = frame_q;
    if (cmd_i.clr_step || cmd_i.scan_next || cmd_i.free_wr) begin
      word_d = word_inc;
    end
    if (cmd_i.alloc_start) begin
      word_d = first_word_ext;
    end
    if (cmd_i.load_in) begin
      count_d = in_count_i;
      frame_d = in_frame_i;
    end
    if (cmd_i.scan_hit) begin
      bit_d = hit_pos;
    end
    if (cmd_i.free_init) begin
      // word size is a power of two: word and bit are slices of the frame number
      word_d = CW'(frame_q >> BIW);
      bit_d  = frame_q[BIW-1:0];
    end
    if (cmd_i.free_wr) begin
      count_d = count_q - take[COUNT_W-1:0];
      bit_d   = '0;
    end
  end

  // Result frame number of a successful allocate
  logic [PW-1:0]      frame_full;
  logic [FRAME_W-1:0] res_frame;

  assign frame_full = PW'(word_q) * PW'(WORD_BITS) + PW'(bit_q);
  assign res_frame  = (rstat_q == ST_DONE && op_q == OP_ALLOC) ? frame_full[FRAME_W-1:0]
                                                                : '0;

  assign out_valid_d = cmd_i.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q   <= bit_d;
    count_q <= count_d;
    frame_q <= frame_d;
    if (cmd_i.load_in) begin
      op_q <= in_op_i;
    end
    if (cmd_i.set_status) begin
      rstat_q <= cmd_i.status_val;
    end
    if (cmd_i.load_out) begin
      out_status_q <= rstat_q;
      out_frame_q  <= res_frame;
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o               = '0;
    stat_o.clr_last      = (word_q == WORDS_C - CW'(1));
    stat_o.bad_count     = (count_q == '0);
    stat_o.op_free       = (op_q == OP_FREE);
    stat_o.no_search     = (8'(count_q) > WB8) || (first_word_ext >= limit);
    stat_o.scan_hit      = |fit;
    stat_o.scan_end      = (word_inc >= limit);
    stat_o.free_past_end = (word_q >= WORDS_C);
    stat_o.free_last     = (8'(count_q) == take);
    stat_o.out_busy      = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_frame_o  = out_frame_q;

endmodule

// File: hdl/bitmap_frame_allocator.sv
// Bitmap frame allocator: a first-fit allocate searches one bitmap word per cycle.
// A zero count, or an allocate with a count wider than a word or an empty search range, gets its
// result without a search; a free reads and rewrites each word it touches and stops past the map.
// Throughput: one word in flight; the next is taken the cycle after the result is loaded,
// even while that result still waits on m_axis_tready.
// Reset: a pass over all BITMAP_WORDS words clears the map to free; no word is accepted meanwhile.
`timescale 1ns / 1ps

module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int unsigned BITMAP_WORDS = 64,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // count[5:0], frame_index[16:6], zero[23:17]
  input  logic [OP_W-1:0]        s_axis_tuser,  // op[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // status[1:0], alloc_frame[12:2], zero[15:13]
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  bfa_cmd_t            cmd;
  bfa_stat_t           stat;
  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0]  out_frame;

  assign cfg_ready_o = 1'b1;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfa_dp #(
    .BITMAP_WORDS (BITMAP_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser),
    .in_count_i   (s_axis_tdata[COUNT_W-1:0]),
    .in_frame_i   (s_axis_tdata[COUNT_W +: FRAME_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_frame_o  (out_frame)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - STATUS_W - FRAME_W){1'b0}}, out_frame, out_status};

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten");

  // At most one bitmap write source per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.scan_hit, cmd.free_wr}))
    else $error("conflicting bitmap writes");

  // One word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while another is in flight");

  // Failed allocates and frees report frame zero
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] != ST_DONE) |-> m_axis_tdata[12:2] == '0)
    else $error("nonzero frame on failed request");

endmodule

// File: verif/bfa_checker.sv
// Checker for the bitmap frame allocator: tracks the frame map, predicts each reply, compares.
`timescale 1ns / 1ps

module bfa_checker import bfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // count[5:0], frame_index[16:6], zero[23:17]
  input  logic [OP_W-1:0]        s_axis_tuser,  // op[0]
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // status[1:0], alloc_frame[12:2], zero[15:13]
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int MAP_WORDS = 64;
  localparam int MAP_BITS  = 32;

  typedef struct packed {
    bfa_status_e        status;
    logic [FRAME_W-1:0] alloc_frame;
  } frame_reply_t;

  logic [MAP_BITS-1:0] used_map [MAP_WORDS];
  logic [WIU_W-1:0]    words_in_use_q;
  logic [FW_W-1:0]     first_word_q;
  frame_reply_t        frame_replies_q [$];
  frame_reply_t        exp_reply;
  frame_reply_t        got_reply;

  // Applies one request to the local frame map and returns the reply it should produce.
  function automatic frame_reply_t apply_frame_request(input logic [OP_W-1:0] op,
                                                       input logic [COUNT_W-1:0] cnt,
                                                       input logic [FRAME_W-1:0] fidx);
    frame_reply_t        rep;
    logic [MAP_BITS-1:0] run;
    int                  limit;
    int                  f;
    rep.status      = ST_DONE;
    rep.alloc_frame = '0;
    if (cnt == 0) begin
      rep.status = ST_BADREQ;
    end else if (op == OP_ALLOC) begin
      rep.status = ST_NOROOM;
      limit = (words_in_use_q > MAP_WORDS) ? MAP_WORDS : int'(words_in_use_q);
      if (cnt <= MAP_BITS) begin
        run = {MAP_BITS{1'b1}} >> (MAP_BITS - cnt);
        for (int w = int'(first_word_q); w < limit; w++) begin
          for (int p = 0; p + cnt <= MAP_BITS; p++) begin
            if (rep.status == ST_NOROOM && (used_map[w] & (run << p)) == '0) begin
              used_map[w]     = used_map[w] | (run << p);
              rep.alloc_frame = FRAME_W'(w * MAP_BITS + p);
              rep.status      = ST_DONE;
            end
          end
        end
      end
    end else begin
      // frame by frame, so a run may cross words; frames past the map drop out
      for (int i = 0; i < cnt; i++) begin
        f = int'(fidx) + i;
        if (f / MAP_BITS < MAP_WORDS) used_map[f / MAP_BITS][f % MAP_BITS] = 1'b0;
      end
    end
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (used_map[w]) used_map[w] = '0;
      words_in_use_q = WORDS_IN_USE_RST;
      first_word_q   = FIRST_WORD_RST;
      frame_replies_q.delete();
      fail_count_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_reply.status      = bfa_status_e'(m_axis_tdata[STATUS_W-1:0]);
        got_reply.alloc_frame = m_axis_tdata[STATUS_W +: FRAME_W];
        if (frame_replies_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected word: status %0d frame %0d", got_reply.status,
                     got_reply.alloc_frame);
          fail_count_o++;
        end else begin
          exp_reply = frame_replies_q.pop_front();
          if (exp_reply != got_reply) begin
            if (fail_count_o < 10)
              $display("mismatch: expected status %0d frame %0d, got status %0d frame %0d",
                       exp_reply.status, exp_reply.alloc_frame,
                       got_reply.status, got_reply.alloc_frame);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WORDS_IN_USE) words_in_use_q = cfg_data_i[WIU_W-1:0];
        else if (cfg_index_i == CFG_FIRST_WORD) first_word_q = cfg_data_i[FW_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        frame_replies_q.push_back(apply_frame_request(s_axis_tuser,
                                                      s_axis_tdata[COUNT_W-1:0],
                                                      s_axis_tdata[COUNT_W +: FRAME_W]));
    end
    pending_o = frame_replies_q.size();
  end

endmodule

// File: verif/bitmap_frame_allocator_tb.sv
// Testbench top for the bitmap frame allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb import bfa_pkg::*; ();

  localparam int CYCLE_LIMIT = 600000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int words_sent = 0;
  bit no_idle = 1'b0;
  int cur_lo = 0;   // first word searched
  int cur_hi = 64;  // search limit, clamped to the map

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bitmap_frame_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bfa_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall before each word, none in no_idle phases.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input int cnt, input int fidx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, FRAME_W'(fidx), COUNT_W'(cnt)};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    words_sent++;
  endtask

  // Stop the request stream and let every reply come back.
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] wiu, input logic [CFG_DATA_W-1:0] fw);
    drain_replies();
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_WORDS_IN_USE, wiu);
      cfg_write(CFG_FIRST_WORD, fw);
    end else begin
      cfg_write(CFG_FIRST_WORD, fw);
      cfg_write(CFG_WORDS_IN_USE, wiu);
    end
    cur_lo = int'(fw[FW_W-1:0]);
    cur_hi = (wiu > 64) ? 64 : int'(wiu);
  endtask

  initial begin
    int n_items;
    int r;
    int sub;
    int cnt;
    int fidx;
    int wiu;
    int fw;
    int span;
    logic [OP_W-1:0] op;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_WORDS_IN_USE;
    cfg_data_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings
    send_word(OP_ALLOC, 0, 0);      // zero count
    send_word(OP_FREE, 0, 2047);    // zero count on free
    send_word(OP_ALLOC, 1, 2047);   // run at bit 0
    send_word(OP_ALLOC, 31, 0);
    send_word(OP_ALLOC, 32, 0);     // whole word
    send_word(OP_ALLOC, 33, 0);     // wider than a word
    send_word(OP_ALLOC, 63, 1365);
    send_word(OP_FREE, 32, 16);     // crosses a word boundary
    send_word(OP_FREE, 32, 16);     // already free
    send_word(OP_FREE, 63, 2040);   // runs past the map
    send_word(OP_FREE, 1, 0);
    set_config(7'd1, 7'd0);
    send_word(OP_ALLOC, 16, 0);
    send_word(OP_ALLOC, 32, 0);
    set_config(7'd0, 7'd0);         // nothing to search
    send_word(OP_ALLOC, 1, 0);
    set_config(7'd127, 7'd63);      // limit clamps to the map, last word only
    send_word(OP_ALLOC, 32, 0);
    send_word(OP_ALLOC, 1, 0);
    send_word(OP_FREE, 32, 2016);
    set_config(7'd64, 7'h7F);       // upper data bit dropped
    send_word(OP_ALLOC, 5, 0);
    set_config(7'd10, 7'd20);       // first word past the limit
    send_word(OP_ALLOC, 1, 0);

    // random phases
    while (words_sent < 1420) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       wiu = 0;
        1:       wiu = 1;
        2:       wiu = 64;
        3:       wiu = $urandom_range(65, 127);
        4, 5:    wiu = $urandom_range(1, 8);
        default: wiu = $urandom_range(1, 64);
      endcase
      span = (wiu > 64) ? 64 : wiu;
      r = $urandom_range(0, 9);
      if (r <= 5) fw = (span > 0) ? $urandom_range(0, span - 1) : 0;
      else if (r == 6) fw = 63;
      else if (r == 7) fw = $urandom_range(0, 127);
      else fw = 0;
      set_config(CFG_DATA_W'(wiu), CFG_DATA_W'(fw));
      no_idle = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(40, 120);
      repeat (n_items) begin
        r = $urandom_range(0, 99);
        sub = $urandom_range(0, 19);
        span = cur_hi - cur_lo;
        if (r < 55) begin
          op = OP_ALLOC;
          if (sub == 0) cnt = 0;
          else if (sub == 1) cnt = $urandom_range(33, 63);
          else if (sub <= 4) cnt = $urandom_range(9, 32);
          else cnt = $urandom_range(1, 8);
          fidx = $urandom_range(0, 2047);
        end else if (r < 90) begin
          op = OP_FREE;
          if (sub == 0) cnt = 0;
          else if (sub <= 2) cnt = $urandom_range(9, 63);
          else cnt = $urandom_range(1, 8);
          if (span > 0) fidx = cur_lo * 32 + $urandom_range(0, span * 32 - 1);
          else fidx = $urandom_range(0, 2047);
        end else begin
          op   = OP_W'($urandom_range(0, 1));
          cnt  = $urandom_range(0, 63);
          fidx = $urandom_range(0, 2047);
        end
        send_word(op, cnt, fidx);
      end
    end

    no_idle = 1'b0;
    drain_replies();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
